// ===== src/scps_pkg.sv =====
// ============================================================================
// scps_pkg
// Types and constants shared by the sample clip playback sequencer.
// ============================================================================
package scps_pkg;

    // Sample store geometry
    localparam int STORE_WORDS = 32768;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int IDX_W       = 16;   // holds STORE_WORDS itself

    // Each stored word is output HOLD_REPEATS+1 times
    localparam int HOLD_REPEATS = 2;
    localparam int HOLD_W       = 2;

    // Gap is given in ms, time runs in tenth-ms units
    localparam int GAP_SCALE = 10;
    localparam int GAP_W     = 20;

    localparam logic [15:0] SIGN_FLIP = 16'h8000;

    // Action codes
    localparam logic [1:0] ACT_REQUEST = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;

    // Start status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_time;
        logic [7:0]  repeats;
        logic [15:0] bursts;
        logic [15:0] gap_ms;
        logic [14:0] load_index;
        logic [15:0] load_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         start_status;
        logic               playing;
    } t_out;

    // Store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
    } t_store_wr;

    // Store read request (index may lie past the store)
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_store_rd;

    // Store read response
    typedef struct packed {
        logic [15:0] data;
        logic        ok;
        logic [15:0] word0;
    } t_store_rsp;

endpackage

// ===== src/scps_store.sv =====
// ============================================================================
// scps_store
// Sample store: one write port, one registered read port, plus a shadow
// copy of word 0 so a clip restart never needs a second read.
// ============================================================================
module scps_store
    import scps_pkg::*;
(
    input  logic       i_clk,
    input  t_store_wr  i_wr,
    input  t_store_rd  i_rd,
    output t_store_rsp o_rsp
);

    logic [15:0] r_mem [STORE_WORDS];
    logic [15:0] r_rd_data;
    logic        r_rd_ok;
    logic [15:0] r_word0;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, index past the store reads as empty
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx[ADDR_W-1:0]];
            r_rd_ok   <= (32'(i_rd.idx) < STORE_WORDS);
        end
    end

    // Word 0 shadow
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.addr == '0)) begin
            r_word0 <= i_wr.data;
        end
    end

    assign o_rsp.data  = r_rd_data;
    assign o_rsp.ok    = r_rd_ok;
    assign o_rsp.word0 = r_word0;

endmodule

// ===== src/scps_seq.sv =====
// ============================================================================
// scps_seq
// Playback state: hold count, clip position, repeat and burst counters and
// gap timing. Updates on commit of one item and forwards the next fetch
// index to the store read issued in the same cycle.
// ============================================================================
module scps_seq
    import scps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_commit,
    input  t_in              i_item,
    input  logic [15:0]      i_clip_bytes,
    input  t_store_rsp       i_rsp,
    output logic [IDX_W-1:0] o_fetch_idx,
    output t_out             o_result
);

    logic [15:0]       r_current, n_current;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [IDX_W-1:0]  r_fetch_idx, n_fetch_idx;   // word index of next fetch
    logic [7:0]        r_repeats_left, n_repeats_left;
    logic [7:0]        r_repeats_reload, n_repeats_reload;
    logic [15:0]       r_bursts_left, n_bursts_left;
    logic [GAP_W-1:0]  r_gap_ticks, n_gap_ticks;
    logic [31:0]       r_resume_time, n_resume_time;

    logic        wrap;
    logic        silent;
    logic [7:0]  rl_dec;
    logic [15:0] word_rd;
    logic [15:0] word_first;

    assign wrap       = ({r_fetch_idx, 1'b0} >= {{(IDX_W-15){1'b0}}, i_clip_bytes});
    assign silent     = (r_bursts_left == '0) || (i_item.now_time < r_resume_time);
    assign rl_dec     = r_repeats_left - 8'd1;
    assign word_rd    = i_rsp.ok ? (i_rsp.data ^ SIGN_FLIP) : 16'd0;
    assign word_first = i_rsp.word0 ^ SIGN_FLIP;

    // Next state and result
    always_comb begin
        n_current        = r_current;
        n_hold           = r_hold;
        n_fetch_idx      = r_fetch_idx;
        n_repeats_left   = r_repeats_left;
        n_repeats_reload = r_repeats_reload;
        n_bursts_left    = r_bursts_left;
        n_gap_ticks      = r_gap_ticks;
        n_resume_time    = r_resume_time;
        o_result         = '0;
        if (i_commit) begin
            unique case (i_item.action)
                ACT_REQUEST: begin
                    if (silent) begin
                        n_current = '0;
                    end else if (r_hold != '0) begin
                        n_hold = r_hold - HOLD_W'(1);
                    end else begin
                        n_hold = HOLD_W'(HOLD_REPEATS);
                        if (wrap) begin
                            // clip end: back to word 0, count the pass
                            n_fetch_idx    = IDX_W'(1);
                            n_current      = word_first;
                            n_repeats_left = rl_dec;
                            if (rl_dec == '0) begin
                                n_repeats_left = r_repeats_reload;
                                n_resume_time  = i_item.now_time + 32'(r_gap_ticks);
                                n_bursts_left  = r_bursts_left - 16'd1;
                            end
                        end else begin
                            n_fetch_idx = r_fetch_idx + IDX_W'(1);
                            n_current   = word_rd;
                        end
                    end
                    o_result.sample = n_current;
                end
                ACT_START: begin
                    if (r_bursts_left != '0) begin
                        o_result.start_status = ST_BUSY;
                    end else if (17'(i_clip_bytes) > 17'(2 * STORE_WORDS)) begin
                        o_result.start_status = ST_TOO_LONG;
                    end else begin
                        n_repeats_left   = i_item.repeats;
                        n_repeats_reload = i_item.repeats;
                        n_bursts_left    = i_item.bursts;
                        n_gap_ticks      = GAP_W'(i_item.gap_ms) * GAP_W'(GAP_SCALE);
                        n_hold           = HOLD_W'(HOLD_REPEATS);
                        n_fetch_idx      = IDX_W'(1);
                        n_current        = word_first;
                    end
                end
                default: begin
                end
            endcase
            o_result.playing = (n_bursts_left != '0);
        end
    end

    assign o_fetch_idx = n_fetch_idx;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current        <= '0;
            r_hold           <= '0;
            r_fetch_idx      <= IDX_W'(1);
            r_repeats_left   <= '0;
            r_repeats_reload <= '0;
            r_bursts_left    <= '0;
            r_gap_ticks      <= '0;
            r_resume_time    <= '0;
        end else begin
            r_current        <= n_current;
            r_hold           <= n_hold;
            r_fetch_idx      <= n_fetch_idx;
            r_repeats_left   <= n_repeats_left;
            r_repeats_reload <= n_repeats_reload;
            r_bursts_left    <= n_bursts_left;
            r_gap_ticks      <= n_gap_ticks;
            r_resume_time    <= n_resume_time;
        end
    end

endmodule

// ===== src/sample_clip_playback_sequencer.sv =====
// ============================================================================
// sample_clip_playback_sequencer
// Plays a loadable 16-bit sample clip in repeated bursts with silent gaps,
// one output sample per input transaction.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (clip_bytes)
//
// One transaction per cycle unless the output stalls; each passes the processing
// stage, then the output register. The store read is launched at acceptance,
// addressed by the fetch index forwarded from the transaction committing in
// that same cycle. Reset clears the sequencing state only; store contents are
// undefined until loaded, with no clearing pass. A stalled output holds one
// result while one more transaction waits in the processing stage.
// ============================================================================
module sample_clip_playback_sequencer
    import scps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_s1_valid;
    t_in         r_s1_item;
    logic        r_out_valid;
    t_out        r_out_data;
    logic [15:0] r_clip_bytes;

    logic             advance;
    logic             commit;
    logic             in_fire;
    logic [IDX_W-1:0] fetch_idx;
    t_out             result;
    t_store_wr        st_wr;
    t_store_rd        st_rd;
    t_store_rsp       st_rsp;

    // Pipeline handshake
    assign advance    = !r_out_valid || i_out_ready;
    assign commit     = r_s1_valid && advance;
    assign o_in_ready = !r_s1_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    // Configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_bytes <= '0;
        end else if (i_cfg_valid) begin
            r_clip_bytes <= i_cfg_data;
        end
    end

    // Store access issued at acceptance
    always_comb begin
        st_wr.en   = in_fire && (i_in_data.action == ACT_LOAD)
                     && (32'(i_in_data.load_index) < STORE_WORDS);
        st_wr.addr = i_in_data.load_index[ADDR_W-1:0];
        st_wr.data = i_in_data.load_value;
        st_rd.en   = in_fire;
        st_rd.idx  = fetch_idx;
    end

    scps_store u_store (
        .i_clk (i_clk),
        .i_wr  (st_wr),
        .i_rd  (st_rd),
        .o_rsp (st_rsp)
    );

    scps_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (commit),
        .i_item       (r_s1_item),
        .i_clip_bytes (r_clip_bytes),
        .i_rsp        (st_rsp),
        .o_fetch_idx  (fetch_idx),
        .o_result     (result)
    );

    // Processing stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (commit) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/sv/tb.sv =====
// ============================================================================
// tb
// Self-checking testbench for the sample clip playback sequencer. A directed
// opening covers idle requests, loads, busy and zero-burst starts and the
// silent gap. Random phases follow, each with its own clip length. Both
// channels idle at random. A scoreboard predicts every result and compares
// it field by field with what the block returns.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scps_pkg::*;

    // Action code the block treats as a no-op
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    // Watchdog limit, with wide margin above the longest legal quiet stretch
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         RANDOM_ITEMS = 1800;
    localparam int         PHASES       = 8;

    // ------------------------------------------------------------------------
    // Playback predictor and store of expected results
    // ------------------------------------------------------------------------
    class playback_scoreboard;
        localparam int MAX_PRINTED = 40;

        logic [15:0]      store_words [int];
        logic [15:0]      cur_sample   = '0;
        logic [1:0]       hold_left    = '0;
        logic [15:0]      byte_pos     = '0;
        logic [7:0]       plays_left   = '0;
        logic [7:0]       plays_reload = '0;
        logic [15:0]      bursts_left  = '0;
        logic [GAP_W-1:0] gap_ticks    = '0;
        logic [31:0]      resume_at    = '0;
        logic [15:0]      clip_bytes   = '0;
        t_out             expected_q[$];
        int               errors       = 0;
        int               results_seen = 0;

        function void set_clip_bytes(logic [15:0] bytes);
            clip_bytes = bytes;
        endfunction

        function bit is_playing();
            return bursts_left != 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Stored word with the top bit flipped; past the store reads zero
        function logic [15:0] word_at(logic [16:0] pos);
            int idx;
            idx = int'(pos >> 1);
            if (idx >= STORE_WORDS || !store_words.exists(idx))
                return '0;
            return store_words[idx] ^ SIGN_FLIP;
        endfunction

        // Does this transaction read the store, and at which word
        function bit next_fetch(t_in it, output int idx);
            logic [16:0] pos;
            idx = 0;
            if (it.action == ACT_START)
                return bursts_left == 0 && int'(clip_bytes) <= 2 * STORE_WORDS;
            if (it.action != ACT_REQUEST || bursts_left == 0 ||
                it.now_time < resume_at || hold_left != 0)
                return 1'b0;
            pos = {1'b0, byte_pos} + 17'd2;
            if (pos >= {1'b0, clip_bytes})
                pos = '0;
            idx = int'(pos >> 1);
            return 1'b1;
        endfunction

        function bit needs_load(t_in it, output int idx);
            return next_fetch(it, idx) && idx < STORE_WORDS && !store_words.exists(idx);
        endfunction

        function t_out play_item(t_in it);
            t_out        res;
            logic [16:0] pos;
            res = '0;
            res.start_status = ST_OK;
            case (it.action)
                ACT_REQUEST: begin
                    if (bursts_left == 0 || it.now_time < resume_at) begin
                        // idle or inside the gap: silence, and forget the held word
                        cur_sample = '0;
                    end else if (hold_left != 0) begin
                        hold_left = hold_left - 2'd1;
                    end else begin
                        pos = {1'b0, byte_pos} + 17'd2;
                        // clip end: one play done, maybe a whole burst
                        if (pos >= {1'b0, clip_bytes}) begin
                            pos        = '0;
                            plays_left = plays_left - 8'd1;
                            if (plays_left == 0) begin
                                plays_left  = plays_reload;
                                resume_at   = it.now_time + 32'(gap_ticks);
                                bursts_left = bursts_left - 16'd1;
                            end
                        end
                        byte_pos   = pos[15:0];
                        cur_sample = word_at(pos);
                        hold_left  = HOLD_W'(HOLD_REPEATS);
                    end
                    res.sample = cur_sample;
                end
                ACT_START: begin
                    if (bursts_left != 0) begin
                        res.start_status = ST_BUSY;
                    end else if (int'(clip_bytes) > 2 * STORE_WORDS) begin
                        res.start_status = ST_TOO_LONG;
                    end else begin
                        plays_left   = it.repeats;
                        plays_reload = it.repeats;
                        bursts_left  = it.bursts;
                        gap_ticks    = GAP_W'(it.gap_ms * GAP_SCALE);
                        hold_left    = HOLD_W'(HOLD_REPEATS);
                        byte_pos     = '0;
                        cur_sample   = word_at('0);
                    end
                end
                ACT_LOAD: begin
                    if (int'(it.load_index) < STORE_WORDS)
                        store_words[int'(it.load_index)] = it.load_value;
                end
                default: begin
                end
            endcase
            res.playing = (bursts_left != 0);
            return res;
        endfunction

        function void note_input(t_in it);
            expected_q.push_back(play_item(it));
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with none expected", results_seen));
                return;
            end
            want = expected_q.pop_front();
            if (got.sample !== want.sample)
                report($sformatf("result %0d: sample %0d, expected %0d",
                                 results_seen, got.sample, want.sample));
            if (got.start_status !== want.start_status)
                report($sformatf("result %0d: start_status %0d, expected %0d",
                                 results_seen, got.start_status, want.start_status));
            if (got.playing !== want.playing)
                report($sformatf("result %0d: playing %0b, expected %0b",
                                 results_seen, got.playing, want.playing));
        endtask

        task check_drained();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    playback_scoreboard sb = new;

    logic [31:0] now_ticks = '0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    logic [15:0] clip_plan [PHASES] = '{16'd16, 16'd0, 16'd2, 16'd65535,
                                        16'd7, 16'd1, 16'd20, 16'd12};

    sample_clip_playback_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in noise_item();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(t_in)-1:0];
    endfunction

    function automatic t_in make_item(logic [1:0] action, logic [31:0] now,
                                      logic [7:0] reps, logic [15:0] bursts,
                                      logic [15:0] gap, logic [14:0] idx,
                                      logic [15:0] val);
        t_in it;
        it.action     = action;
        it.now_time   = now;
        it.repeats    = reps;
        it.bursts     = bursts;
        it.gap_ms     = gap;
        it.load_index = idx;
        it.load_value = val;
        return it;
    endfunction

    // One input transaction; valid stays high afterward for a back-to-back item
    task automatic push_item(input t_in it);
        int idle;
        idle = tx_steady ? 0 : $urandom_range(0, 4);
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    // Load any store word the item is about to read for the first time
    task automatic send_item(input t_in it);
        t_in fill;
        int  idx;
        if (sb.needs_load(it, idx)) begin
            fill            = noise_item();
            fill.action     = ACT_LOAD;
            fill.now_time   = now_ticks;
            fill.load_index = idx[14:0];
            push_item(fill);
        end
        push_item(it);
    endtask

    task automatic write_clip_bytes(input logic [15:0] bytes);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bytes;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_clip_bytes(bytes);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly small time steps, now and then a jump far ahead or anywhere
    function automatic t_in random_item();
        t_in it;
        int  pick;
        it   = noise_item();
        pick = $urandom_range(0, 199);
        if (pick == 0)
            now_ticks = $urandom();
        else if (pick < 3)
            now_ticks = now_ticks + $urandom_range(0, 700000);
        else
            now_ticks = now_ticks + $urandom_range(0, 12);
        it.now_time = now_ticks;

        pick = $urandom_range(0, 99);
        if (sb.is_playing()) begin
            // starts here are refused as busy, so their fields stay wide
            if (pick < 86)
                it.action = ACT_REQUEST;
            else if (pick < 91)
                it.action = ACT_START;
            else if (pick < 98)
                it.action = ACT_LOAD;
            else
                it.action = ACT_UNUSED;
        end else if (pick < 25) begin
            it.action  = ACT_START;
            it.repeats = ($urandom_range(0, 39) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
            it.bursts  = 16'($urandom_range(0, 4));
            it.gap_ms  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 15));
        end else if (pick < 75) begin
            it.action = ACT_REQUEST;
        end else if (pick < 95) begin
            it.action = ACT_LOAD;
        end else begin
            it.action = ACT_UNUSED;
        end

        // keep many loads on the words the clip actually plays
        if (it.action == ACT_LOAD && $urandom_range(0, 1) == 1)
            it.load_index = 15'($urandom_range(0, 31));
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Result sink with random stalls
    // ------------------------------------------------------------------------
    initial begin : sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 49) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transaction on any channel
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sample_clip_playback_sequencer test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two-word clip
        write_clip_bytes(16'd4);
        send_item(make_item(ACT_REQUEST, 32'd0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                            15'h7FFF, 16'hFFFF));
        send_item(make_item(ACT_LOAD, 32'd0, 0, 0, 0, 15'd0, 16'h0000));
        send_item(make_item(ACT_LOAD, 32'd0, 0, 0, 0, 15'd1, 16'hFFFF));
        send_item(make_item(ACT_LOAD, 32'd0, 0, 0, 0, 15'h7FFF, 16'h8000));
        // two bursts of one play, 1 ms gap; then a start while busy
        send_item(make_item(ACT_START, 32'd0, 8'd1, 16'd2, 16'd1, 0, 0));
        send_item(make_item(ACT_START, 32'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0));
        repeat (6) send_item(make_item(ACT_REQUEST, 32'd100, 0, 0, 0, 0, 0));
        // inside the gap, then the second burst
        send_item(make_item(ACT_REQUEST, 32'd109, 0, 0, 0, 0, 0));
        repeat (7) send_item(make_item(ACT_REQUEST, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        // zero bursts: accepted, nothing plays
        send_item(make_item(ACT_START, 32'd0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_REQUEST, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        wait_drained();

        // Random phases, each with its own clip length
        now_ticks    = $urandom();
        clip_plan[6] = 16'($urandom_range(2, 40));
        for (int ph = 0; ph < PHASES; ph++) begin
            write_clip_bytes(clip_plan[ph]);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (n % 64 == 0)
                    tx_steady = ($urandom_range(0, 3) == 0);
                send_item(random_item());
            end
            wait_drained();
        end

        sb.check_drained();
        if (sb.errors == 0) begin
            $display("sample_clip_playback_sequencer test passed");
        end else begin
            $display("sample_clip_playback_sequencer test failed");
        end
        $finish;
    end

endmodule
